FILE: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// No dependencies. Used by every module in the project.
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_DEPTH = 64;

    localparam int PRI_W  = 8;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/spq_ctrl.sv
// Sequencing controller for the stable priority queue.
// Depends on spq_pkg for the command struct.
`default_nettype none

module spq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output spq_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == S_EXEC);
    assign done     = done_reg;
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

`default_nettype wire

FILE: hdl/spq_datapath.sv
// Sorted slot array, command latch and result registers of the queue.
// Depends on spq_pkg for widths, codes and the command struct.
`default_nettype none

module spq_datapath
#(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire spq_pkg::ctrl_cmd_t          cmd,
    input  wire logic                        action,
    input  wire logic [spq_pkg::PRI_W-1:0]   entry_priority,
    input  wire logic [spq_pkg::TAG_W-1:0]   entry_tag,
    output logic [spq_pkg::STAT_W-1:0]       status,
    output logic [spq_pkg::PRI_W-1:0]        out_priority,
    output logic [spq_pkg::TAG_W-1:0]        out_tag,
    output logic [spq_pkg::OCC_W-1:0]        occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                        act_reg;
    logic [spq_pkg::PRI_W-1:0]   pri_reg;
    logic [spq_pkg::TAG_W-1:0]   tag_reg;

    logic [spq_pkg::PRI_W-1:0]   slot_pri_reg [QUEUE_DEPTH];
    logic [spq_pkg::TAG_W-1:0]   slot_tag_reg [QUEUE_DEPTH];
    logic [CW-1:0]               count_reg, count_next;

    spq_pkg::status_t            status_reg, status_next;
    logic [spq_pkg::PRI_W-1:0]   opri_reg, opri_next;
    logic [spq_pkg::TAG_W-1:0]   otag_reg, otag_next;

    logic                        full;
    logic                        empty;
    logic                        do_insert;
    logic                        do_pop;
    logic [QUEUE_DEPTH-1:0]      ge;
    logic [CW+spq_pkg::OCC_W-1:0] count_ext;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_insert = cmd.exec && (act_reg == spq_pkg::ACT_INSERT) && !full;
    assign do_pop    = cmd.exec && (act_reg == spq_pkg::ACT_POP) && !empty;

    // Latch the command beat on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            pri_reg <= entry_priority;
            tag_reg <= entry_tag;
        end
    end

    // Each held slot at or above the new priority stays ahead of it
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_slot
            assign ge[i] = (CW'(i) < count_reg) && (slot_pri_reg[i] >= pri_reg);

            always_ff @(posedge clk)
            begin
                if (do_insert && !ge[i])
                begin
                    if (i == 0)
                    begin
                        slot_pri_reg[i] <= pri_reg;
                        slot_tag_reg[i] <= tag_reg;
                    end
                    else if (ge[(i == 0) ? 0 : i-1])
                    begin
                        slot_pri_reg[i] <= pri_reg;
                        slot_tag_reg[i] <= tag_reg;
                    end
                    else
                    begin
                        slot_pri_reg[i] <= slot_pri_reg[(i == 0) ? 0 : i-1];
                        slot_tag_reg[i] <= slot_tag_reg[(i == 0) ? 0 : i-1];
                    end
                end
                else if (do_pop && (i < QUEUE_DEPTH-1))
                begin
                    // advance towards the front
                    slot_pri_reg[i] <= slot_pri_reg[(i < QUEUE_DEPTH-1) ? i+1 : i];
                    slot_tag_reg[i] <= slot_tag_reg[(i < QUEUE_DEPTH-1) ? i+1 : i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        opri_next   = opri_reg;
        otag_next   = otag_reg;
        if (cmd.exec)
        begin
            opri_next = '0;
            otag_next = '0;
            if (act_reg == spq_pkg::ACT_INSERT)
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_INSERTED;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = spq_pkg::ST_POPPED;
                    opri_next   = slot_pri_reg[0];
                    otag_next   = slot_tag_reg[0];
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        opri_reg   <= opri_next;
        otag_reg   <= otag_next;
    end

    // Occupancy carries the low bits of the count, zero-extended when narrower
    assign count_ext    = {{spq_pkg::OCC_W{1'b0}}, count_reg};
    assign occupancy    = count_ext[spq_pkg::OCC_W-1:0];
    assign status       = status_reg;
    assign out_priority = opri_reg;
    assign out_tag      = otag_reg;

endmodule

`default_nettype wire

FILE: hdl/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus sorted slot datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  channel   handshake              payload
//  command   start, busy            action, entry_priority, entry_tag
//  result    done (one-cycle beat)  status, out_priority, out_tag, occupancy
//
// A command beat is taken when start is high and busy is low. busy then stays
// high for one cycle while the whole slot array compares against the new
// priority and shifts in a single step; the result beat follows in the next
// cycle, during which a new command may already be taken. The receiver cannot
// stall, so results are never held back.
// Reset clears the controller and the fill count; slot contents need no clearing.
`default_nettype none

module stable_priority_queue
#(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        action,
    input  wire logic [spq_pkg::PRI_W-1:0]   entry_priority,
    input  wire logic [spq_pkg::TAG_W-1:0]   entry_tag,
    output logic                             done,
    output logic [spq_pkg::STAT_W-1:0]       status,
    output logic [spq_pkg::PRI_W-1:0]        out_priority,
    output logic [spq_pkg::TAG_W-1:0]        out_tag,
    output logic [spq_pkg::OCC_W-1:0]        occupancy
);

    spq_pkg::ctrl_cmd_t cmd;

    spq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    spq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .action         (action),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .status         (status),
        .out_priority   (out_priority),
        .out_tag        (out_tag),
        .occupancy      (occupancy)
    );

endmodule

`default_nettype wire

FILE: hdl/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
// Depends on spq_pkg for widths and status codes.
`default_nettype none

module spq_checker
#(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        done,
    input  wire logic [spq_pkg::STAT_W-1:0]  status,
    input  wire logic [spq_pkg::PRI_W-1:0]   out_priority,
    input  wire logic [spq_pkg::TAG_W-1:0]   out_tag,
    input  wire logic [spq_pkg::OCC_W-1:0]   occupancy
);

    localparam int QD = QUEUE_DEPTH;

    // An accepted beat makes the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command beat");

    // Every accepted beat yields its result beat once the execute state has passed
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result beat missing");

    // Result beats never come in adjacent cycles
    a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // A pop on empty reports nothing held and carries zero payload
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == spq_pkg::ST_EMPTY) |->
            (occupancy == '0) && (out_priority == '0) && (out_tag == '0))
        else $error("pop on empty result malformed");

    // An insert never changes the popped payload fields from zero
    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((status == spq_pkg::ST_INSERTED) || (status == spq_pkg::ST_FULL)) |->
            (out_priority == '0) && (out_tag == '0) && (QD > 0))
        else $error("insert result carries payload");

endmodule

bind stable_priority_queue spq_checker
#(
    .QUEUE_DEPTH (QUEUE_DEPTH)
)
u_spq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .occupancy    (occupancy)
);

`default_nettype wire
